// ===== hw/rtl/tmcw_pkg.sv =====
// shared types and constants for the text-mode console writer
package tmcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;
    localparam logic [3:0] FOREGROUND_RESET = 4'd7;
    localparam logic [3:0] BACKGROUND_RESET = 4'd0;

    // character and cell codes
    localparam logic [7:0]  NULL_CHAR    = 8'h00;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [15:0] BLANK_CELL   = 16'h0020;

    // transaction modes
    typedef enum logic [1:0] {
        MODE_PRINT = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

    // result status from sequencer to top level
    typedef struct packed {
        logic done;
        logic accepted;
        logic scrolled;
        logic cell_sel;
    } result_t;

endpackage

// ===== hw/rtl/tmcw_screen_ram.sv =====
// single-port-write, registered-read screen cell memory
module tmcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tmcw_ctrl.sv =====
// sequencer: cursor, clearing pass, print/write/read and scroll copy
module tmcw_ctrl #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = $clog2(CELLS),
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  logic [7:0]          char_code,
    input  logic [7:0]          pos_x,
    input  logic [5:0]          pos_y,
    input  logic [7:0]          attr,
    input  logic [15:0]         rdata,
    output logic                busy,
    output logic [COL_W-1:0]    col,
    output logic [ROW_W-1:0]    line,
    output tmcw_pkg::result_t   res,
    output logic                mem_we,
    output logic [ADDR_W-1:0]   mem_waddr,
    output logic [15:0]         mem_wdata,
    output logic [ADDR_W-1:0]   mem_raddr
);

    localparam int CNT_W = $clog2(CELLS + 1);

    tmcw_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  line_reg, line_next;
    logic              accepted_reg, accepted_next;
    logic              scrolled_reg, scrolled_next;
    logic              cell_sel_reg, cell_sel_next;

    logic              take;
    logic              pos_ok;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic              at_last_col;
    logic              at_last_row;
    logic [CNT_W-1:0]  copy_dst;

    // address and range decode
    assign take        = start && (state_reg == tmcw_pkg::ST_IDLE);
    assign pos_ok      = ({1'b0, pos_x} < 9'(COLUMNS)) && ({1'b0, pos_y} < 7'(ROWS));
    assign pos_addr    = ADDR_W'(pos_y[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                         + ADDR_W'(pos_x[COL_W-1:0]);
    assign cur_addr    = ADDR_W'(line_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign at_last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (line_reg == ROW_W'(ROWS - 1));
    assign copy_dst    = idx_reg - CNT_W'(COLUMNS + 1);

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tmcw_pkg::ST_CLEAR;
            idx_reg      <= '0;
            col_reg      <= '0;
            line_reg     <= '0;
            accepted_reg <= 1'b0;
            scrolled_reg <= 1'b0;
            cell_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            accepted_reg <= accepted_next;
            scrolled_reg <= scrolled_next;
            cell_sel_reg <= cell_sel_next;
        end
    end

    // next state and memory port control
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        accepted_next = accepted_reg;
        scrolled_next = scrolled_reg;
        cell_sel_next = cell_sel_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr;
        mem_wdata     = {attr, char_code};
        mem_raddr     = pos_addr;

        case (state_reg)
            // blank the whole buffer after reset
            tmcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = tmcw_pkg::BLANK_CELL;
                if (idx_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // accept a transaction, do the single cell access
            tmcw_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next    = tmcw_pkg::ST_RESP;
                    accepted_next = 1'b0;
                    scrolled_next = 1'b0;
                    cell_sel_next = 1'b0;
                    case (mode)
                        tmcw_pkg::MODE_PRINT:
                        begin
                            accepted_next = 1'b1;
                            if (char_code != tmcw_pkg::NULL_CHAR)
                            begin
                                if (char_code != tmcw_pkg::NEWLINE_CHAR)
                                begin
                                    mem_we = 1'b1;
                                end
                                if ((char_code == tmcw_pkg::NEWLINE_CHAR) || at_last_col)
                                begin
                                    col_next = '0;
                                    if (at_last_row)
                                    begin
                                        scrolled_next = 1'b1;
                                        state_next    = tmcw_pkg::ST_SCROLL;
                                        idx_next      = CNT_W'(COLUMNS);
                                    end
                                    else
                                    begin
                                        line_next = line_reg + ROW_W'(1);
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        end
                        tmcw_pkg::MODE_WRITE:
                        begin
                            accepted_next = pos_ok;
                            mem_we        = pos_ok;
                            mem_waddr     = pos_addr;
                        end
                        tmcw_pkg::MODE_READ:
                        begin
                            accepted_next = pos_ok;
                            cell_sel_next = pos_ok;
                        end
                        default:
                        begin
                            accepted_next = 1'b0;
                        end
                    endcase
                end
            end

            // move every line up by one: read ahead, write one row higher
            tmcw_pkg::ST_SCROLL:
            begin
                mem_raddr = idx_reg[ADDR_W-1:0];
                mem_we    = (idx_reg != CNT_W'(COLUMNS));
                mem_waddr = copy_dst[ADDR_W-1:0];
                mem_wdata = rdata;
                if (idx_reg == CNT_W'(CELLS))
                begin
                    state_next = tmcw_pkg::ST_FILL;
                    idx_next   = CNT_W'(CELLS - COLUMNS);
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // blank the bottom line in the current colors
            tmcw_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = {attr, tmcw_pkg::BLANK_CHAR};
                if (idx_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tmcw_pkg::ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // present the result for one cycle
            tmcw_pkg::ST_RESP:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    // status outputs
    assign busy         = (state_reg != tmcw_pkg::ST_IDLE);
    assign col          = col_reg;
    assign line         = line_reg;
    assign res.done     = (state_reg == tmcw_pkg::ST_RESP);
    assign res.accepted = accepted_reg;
    assign res.scrolled = scrolled_reg;
    assign res.cell_sel = cell_sel_reg;

endmodule

// ===== hw/rtl/text_mode_console_writer.sv =====
// top level of the text-mode console writer
// Text-mode console with a COLUMNS x ROWS buffer of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. A transaction is
// taken when start is high and busy is low; its result appears for exactly one
// cycle with done high, and the receiver cannot stall it. After reset the block
// runs a clearing pass that blanks every cell, with busy high. A normal
// transaction is accepted and does its single memory access in the idle
// state, then its result is presented from the response state. A print that
// scrolls copies the buffer through the one-write, one-read cell memory, one
// cell per cycle, and then blanks the bottom line. Color registers are written
// through cfg_we/cfg_index/cfg_data and should only change while busy is low.
module text_mode_console_writer #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     char_code,
    input  logic [7:0]                     pos_x,
    input  logic [5:0]                     pos_y,
    output logic                           done,
    output logic                           accepted,
    output logic [7:0]                     cursor_col,
    output logic [5:0]                     cursor_row,
    output logic                           scrolled,
    output logic [15:0]                    cell_value,
    input  logic                           cfg_we,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  line;
    tmcw_pkg::result_t res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    // color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tmcw_pkg::FOREGROUND_RESET;
            bg_reg <= tmcw_pkg::BACKGROUND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmcw_pkg::CFG_FOREGROUND: fg_reg <= cfg_data[3:0];
                tmcw_pkg::CFG_BACKGROUND: bg_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer
    tmcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .char_code (char_code),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .attr      ({bg_reg, fg_reg}),
        .rdata     (mem_rdata),
        .busy      (busy),
        .col       (col),
        .line      (line),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr)
    );

    // screen cell memory
    tmcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result ports
    assign done       = res.done;
    assign accepted   = res.accepted;
    assign scrolled   = res.scrolled;
    assign cursor_col = 8'(col);
    assign cursor_row = 6'(line);
    assign cell_value = res.cell_sel ? mem_rdata : 16'h0000;

`ifndef ASSERT_OFF
    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // the result strobe lasts a single cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // cursor stays inside the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_col < COLUMNS) && (cursor_row < ROWS))
        else $error("cursor outside the screen");

    // a scroll leaves the cursor at the start of the bottom line
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> ((cursor_col == 8'd0) && (cursor_row == 6'(ROWS - 1))))
        else $error("cursor not at bottom line start after scroll");
`endif

endmodule

// ===== test/tmcw_result_checker.sv =====
`timescale 1ns / 100ps
// result checker for the text-mode console writer: screen model, predictions, field compare
module tmcw_result_checker #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [7:0]                      char_code,
    input  logic [7:0]                      pos_x,
    input  logic [5:0]                      pos_y,
    input  logic                            done,
    input  logic                            accepted,
    input  logic [7:0]                      cursor_col,
    input  logic [5:0]                      cursor_row,
    input  logic                            scrolled,
    input  logic [15:0]                     cell_value,
    input  logic                            cfg_we,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              error_count,
    output int                              pending_count
);
    import tmcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  col;
        logic [5:0]  row;
        logic        scrolled;
        logic [15:0] cell_val;
    } console_result_t;

    // shadow copy of the screen, cursor and colors
    logic [15:0]     screen_copy [CELLS];
    int              cur_col;
    int              cur_row;
    logic [3:0]      fg_color;
    logic [3:0]      bg_color;
    console_result_t predicted_results [$];

    function automatic logic [15:0] colored_cell(logic [7:0] ch);
        return {bg_color, fg_color, ch};
    endfunction

    // update the shadow state for one transaction and return its result
    function automatic console_result_t apply_console_item(mode_t m, logic [7:0] ch,
                                                           logic [7:0] px, logic [5:0] py);
        console_result_t r;
        int              idx;
        r = '0;
        case (m)
            MODE_PRINT:
            begin
                r.accepted = 1'b1;
                // null byte terminates a string and prints nothing
                if (ch != NULL_CHAR)
                begin
                    if (ch == NEWLINE_CHAR)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    else
                    begin
                        screen_copy[cur_row * COLUMNS + cur_col] = colored_cell(ch);
                        cur_col++;
                    end
                    // wrap past the last column
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // scroll up one line, blank bottom line in current colors
                    if (cur_row >= ROWS)
                    begin
                        for (int i = COLUMNS; i < CELLS; i++)
                            screen_copy[i - COLUMNS] = screen_copy[i];
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                            screen_copy[i] = colored_cell(BLANK_CHAR);
                        cur_row    = ROWS - 1;
                        r.scrolled = 1'b1;
                    end
                end
            end
            MODE_WRITE, MODE_READ:
            begin
                if (int'(px) < COLUMNS && int'(py) < ROWS)
                begin
                    idx        = int'(py) * COLUMNS + int'(px);
                    r.accepted = 1'b1;
                    if (m == MODE_WRITE)
                        screen_copy[idx] = colored_cell(ch);
                    else
                        r.cell_val = screen_copy[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.col = 8'(cur_col);
        r.row = 6'(cur_row);
        return r;
    endfunction

    // watch config writes, accepted transactions and results
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen_copy[i] = BLANK_CELL;
            cur_col  = 0;
            cur_row  = 0;
            fg_color = FOREGROUND_RESET;
            bg_color = BACKGROUND_RESET;
            predicted_results.delete();
            pending_count = 0;
        end
        else
        begin
            // results first: they belong to earlier transactions
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                        error_count++;
                    end
                    if (cursor_col !== want.col)
                    begin
                        $error("cursor_col: expected %0d, actual %0d", want.col, cursor_col);
                        error_count++;
                    end
                    if (cursor_row !== want.row)
                    begin
                        $error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
                        error_count++;
                    end
                    if (scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0d, actual %0d", want.scrolled, scrolled);
                        error_count++;
                    end
                    if (cell_value !== want.cell_val)
                    begin
                        $error("cell_value: expected 0x%04h, actual 0x%04h",
                               want.cell_val, cell_value);
                        error_count++;
                    end
                end
            end
            // color register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FOREGROUND: fg_color = cfg_data;
                    CFG_BACKGROUND: bg_color = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // accepted transaction
            if (start && !busy)
                predicted_results.push_back(apply_console_item(mode_t'(mode), char_code,
                                                               pos_x, pos_y));
            pending_count = predicted_results.size();
        end
    end

endmodule

// ===== test/text_mode_console_writer_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the text-mode console writer: stimulus, color phases and verdict
module text_mode_console_writer_tb;
    import tmcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    // worst case: every transaction scrolls after the longest idle gap,
    // plus the clearing pass, taken about four times over
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int PHASE_ITEMS = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic [7:0]            char_code;
    logic [7:0]            pos_x;
    logic [5:0]            pos_y;
    logic                  done;
    logic                  accepted;
    logic [7:0]            cursor_col;
    logic [5:0]            cursor_row;
    logic                  scrolled;
    logic [15:0]           cell_value;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int pending_count;
    int cycle_count;
    int items_sent;
    bit gaps_on;
    bit gaps_allowed;

    text_mode_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .char_code  (char_code),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .done       (done),
        .accepted   (accepted),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .scrolled   (scrolled),
        .cell_value (cell_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tmcw_result_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .char_code     (char_code),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .done          (done),
        .accepted      (accepted),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .scrolled      (scrolled),
        .cell_value    (cell_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_mode_console_writer_tb NOT OK");
        $finish;
    end

    // one transaction, called at a falling edge; start stays high on return
    task automatic send_item(mode_t m, logic [7:0] ch, logic [7:0] x, logic [5:0] y);
        // random idle burst before the transaction
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        start     <= 1'b1;
        mode      <= m;
        char_code <= ch;
        pos_x     <= x;
        pos_y     <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m != MODE_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    // stop issuing and wait until every result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_count != 0 || busy)
            @(negedge clk);
    endtask

    task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FOREGROUND;
        cfg_data  <= fg;
        @(negedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random run of related transactions
    task automatic random_run();
        int          kind;
        int          len;
        bit          in_range;
        logic [7:0]  ch;
        logic [7:0]  x;
        logic [5:0]  y;
        kind    = $urandom_range(0, 99);
        gaps_on = gaps_allowed && ($urandom_range(0, 3) != 0);
        if (kind < 45)
        begin
            // a line of text, often past the last column, mostly ended by newline
            len = $urandom_range(1, 100);
            repeat (len)
            begin
                if ($urandom_range(0, 19) == 0)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = 8'($urandom_range(8'h21, 8'h7e));
                send_item(MODE_PRINT, ch, 8'($urandom_range(0, 255)),
                          6'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 9) < 7)
                send_item(MODE_PRINT, NEWLINE_CHAR, 8'($urandom_range(0, 255)),
                          6'($urandom_range(0, 63)));
        end
        else if (kind < 60)
        begin
            // newline bursts push the cursor down into scrolling
            repeat ($urandom_range(1, 30))
                send_item(MODE_PRINT, NEWLINE_CHAR, 8'($urandom_range(0, 255)),
                          6'($urandom_range(0, 63)));
        end
        else if (kind < 85)
        begin
            // positional writes and reads, a few out of range
            repeat ($urandom_range(1, 8))
            begin
                in_range = ($urandom_range(0, 9) != 0);
                x = in_range ? 8'($urandom_range(0, COLUMNS - 1)) : 8'($urandom_range(0, 255));
                y = in_range ? 6'($urandom_range(0, ROWS - 1)) : 6'($urandom_range(0, 63));
                send_item($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                          8'($urandom_range(0, 255)), x, y);
            end
        end
        else if (kind < 93)
        begin
            // read back a stretch of one row
            y   = 6'($urandom_range(0, ROWS - 1));
            len = $urandom_range(1, 12);
            x   = 8'($urandom_range(0, COLUMNS - len));
            repeat (len)
            begin
                send_item(MODE_READ, 8'($urandom_range(0, 255)), x, y);
                x++;
            end
        end
        else
        begin
            // noise: any mode, any field value
            repeat ($urandom_range(1, 4))
                send_item(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic random_phase(logic [3:0] fg, logic [3:0] bg);
        int target;
        set_colors(fg, bg);
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            random_run();
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_PRINT;
        char_code    = '0;
        pos_x        = '0;
        pos_y        = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FOREGROUND;
        cfg_data     = '0;
        items_sent   = 0;
        gaps_on      = 1'b1;
        gaps_allowed = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset colors, field extremes, every mode, special cases
        send_item(MODE_PRINT, 8'h41, 8'h00, 6'h00);
        send_item(MODE_PRINT, NULL_CHAR, 8'hff, 6'h3f);
        send_item(MODE_PRINT, 8'hff, 8'h00, 6'h00);
        send_item(MODE_PRINT, 8'h80, 8'h00, 6'h00);
        send_item(MODE_PRINT, 8'h01, 8'h00, 6'h00);
        send_item(MODE_PRINT, BLANK_CHAR, 8'h00, 6'h00);
        send_item(MODE_PRINT, NEWLINE_CHAR, 8'h00, 6'h00);
        send_item(MODE_PRINT, 8'h7f, 8'h00, 6'h00);
        send_item(MODE_READ, 8'h00, 8'h00, 6'h00);
        send_item(MODE_READ, 8'h00, 8'h01, 6'h00);
        send_item(MODE_WRITE, 8'h5a, 8'h00, 6'h00);
        send_item(MODE_WRITE, 8'hfe, 8'(COLUMNS - 1), 6'(ROWS - 1));
        send_item(MODE_READ, 8'h00, 8'(COLUMNS - 1), 6'(ROWS - 1));
        send_item(MODE_READ, 8'hff, 8'h00, 6'h00);
        send_item(MODE_WRITE, 8'h11, 8'(COLUMNS), 6'h00);
        send_item(MODE_WRITE, 8'h22, 8'hff, 6'h3f);
        send_item(MODE_WRITE, 8'h33, 8'h00, 6'(ROWS));
        send_item(MODE_READ, 8'h00, 8'(COLUMNS), 6'(ROWS - 1));
        send_item(MODE_READ, 8'h00, 8'h00, 6'h3f);
        send_item(MODE_READ, 8'h00, 8'hff, 6'h00);
        send_item(MODE_READ, 8'h00, 8'h02, 6'h01);
        send_item(MODE_NONE, 8'hff, 8'hff, 6'h3f);
        send_item(MODE_NONE, 8'h41, 8'h00, 6'h00);

        // random phases across color settings, extremes first
        random_phase(4'hf, 4'hf);
        random_phase(4'h0, 4'h0);
        random_phase(4'hf, 4'h0);
        random_phase(4'h0, 4'hf);
        random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        // last part runs back to back
        gaps_allowed = 1'b0;
        random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));

        drain();
        repeat (10) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("text_mode_console_writer_tb OK");
        else
            $display("text_mode_console_writer_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_screen_ram.sv
hw/rtl/tmcw_ctrl.sv
hw/rtl/text_mode_console_writer.sv
test/tmcw_result_checker.sv
test/text_mode_console_writer_tb.sv
